// File: rtl/lsbe_pkg.sv
// Package: shared types, reset values and the channel scaling function.
`timescale 1ns / 1ps
`default_nettype none
package lsbe_pkg;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned LatchW   = 6;
	localparam int unsigned PixBits  = 3 * ChanW;
	localparam int unsigned BitCntW  = $clog2(PixBits + 1);

	localparam logic [ChanW-1:0]  Unscaled   = 8'd255;
	localparam logic [LatchW-1:0] LatchMax   = 6'd40;

	localparam logic [ChanW-1:0]  BrightRst  = 8'd255;
	localparam logic [ChanW-1:0]  ZeroPatRst = 8'd192;
	localparam logic [ChanW-1:0]  OnePatRst  = 8'd248;
	localparam logic [LatchW-1:0] LatchRst   = 6'd40;

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_ZERO_PAT   = 2'd1,
		REG_ONE_PAT    = 2'd2,
		REG_LATCH_CNT  = 2'd3
	} reg_idx_t;

	// Scaled pixel handed to the serializer, bits in green, red, blue order
	typedef struct packed {
		logic [PixBits-1:0] bits;
		logic [LatchW-1:0]  latch;
		logic               last;
	} pix_t;

	function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] v,
			input logic [ChanW-1:0] b);
		logic [2*ChanW:0] prod;
		prod = {1'b0, v} * ({1'b0, b} + 9'd1);
		if (b == Unscaled) begin
			scale_chan = v;
		end else begin
			scale_chan = prod[2*ChanW-1:ChanW];
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/led_strip_bit_pattern_encoder.sv
// Top level: LED strip bit pattern encoder with configuration registers.
//
// Usage
//  - Input channel (in_valid/in_ready): one beat per pixel, fields red, green,
//    blue and last_pixel. Pixels arrive in strip order.
//  - Output channel (out_valid/out_ready): one beat per transmit byte. Each
//    pixel gives 24 pattern bytes (green, red, blue, MSB first); a pixel with
//    last_pixel set is followed by min(latch_byte_count, 40) zero bytes.
//    run_last marks a pixel's final byte, frame_done the frame's final byte.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//    always high; index 0 brightness, 1 zero pattern, 2 one pattern,
//    3 latch byte count. Write only while the block is idle.
//  - A pixel's first byte passes the input, serializer and output registers.
//  - Throughput: one output byte per cycle while out_ready is high. The
//    serializer's bit and latch counters track the bytes left; the next
//    pixel waits in the input register and is loaded the cycle the current
//    one finishes, with no gap.
//  - Reset: clears all valid state and loads the register defaults
//    (brightness 255, patterns 192 and 248, latch count 40).
//  - Stall: with out_ready low the output byte holds and the serializer
//    freezes; one further pixel is taken into the input register, after that
//    in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module led_strip_bit_pattern_encoder import lsbe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ChanW-1:0]  red,
	input  wire logic [ChanW-1:0]  green,
	input  wire logic [ChanW-1:0]  blue,
	input  wire logic              last_pixel,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ChanW-1:0]       tx_byte,
	output logic                   run_last,
	output logic                   frame_done,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [ChanW-1:0]  cfg_data
);

	logic [ChanW-1:0]  brightness_q;
	logic [ChanW-1:0]  zero_pat_q;
	logic [ChanW-1:0]  one_pat_q;
	logic [LatchW-1:0] latch_cnt_q;

	logic              pix_valid;
	logic              pix_take;
	pix_t              pix;

	assign cfg_ready = 1'b1;

	// Register file; the latch count keeps only its low six bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BrightRst;
			zero_pat_q   <= ZeroPatRst;
			one_pat_q    <= OnePatRst;
			latch_cnt_q  <= LatchRst;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				REG_ZERO_PAT:   zero_pat_q   <= cfg_data;
				REG_ONE_PAT:    one_pat_q    <= cfg_data;
				REG_LATCH_CNT:  latch_cnt_q  <= cfg_data[LatchW-1:0];
				default: ;
			endcase
		end
	end

	// Input register and scaling
	lsbe_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel),
		.brightness (brightness_q),
		.latch_cnt  (latch_cnt_q),
		.pix_valid  (pix_valid),
		.pix        (pix),
		.pix_take   (pix_take)
	);

	// Byte serializer and output register
	lsbe_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix        (pix),
		.pix_take   (pix_take),
		.zero_pat   (zero_pat_q),
		.one_pat    (one_pat_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_byte    (tx_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

	// Frame end always closes a pixel run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("frame_done without run_last");

	// Bytes inside a run follow with no gap
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside a pixel run");

	// A pixel waiting in the input register blocks intake until it moves on
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_take |-> !in_ready)
		else $error("input taken over a waiting pixel");

endmodule
`default_nettype wire

// File: rtl/lsbe_scale.sv
// Input pixel register and brightness scaling.
`timescale 1ns / 1ps
`default_nettype none
module lsbe_scale import lsbe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ChanW-1:0]  red,
	input  wire logic [ChanW-1:0]  green,
	input  wire logic [ChanW-1:0]  blue,
	input  wire logic              last_pixel,
	input  wire logic [ChanW-1:0]  brightness,
	input  wire logic [LatchW-1:0] latch_cnt,
	output logic                   pix_valid,
	output pix_t                   pix,
	input  wire logic              pix_take
);

	logic              valid_s1;
	logic [ChanW-1:0]  red_s1, green_s1, blue_s1;
	logic              last_s1;
	logic [LatchW-1:0] latch_sat;

	assign in_ready = !valid_s1 || pix_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			last_s1  <= last_pixel;
		end
	end

	assign latch_sat = (latch_cnt > LatchMax) ? LatchMax : latch_cnt;

	always_comb begin
		pix.bits  = {scale_chan(green_s1, brightness), scale_chan(red_s1, brightness),
			scale_chan(blue_s1, brightness)};
		pix.latch = last_s1 ? latch_sat : '0;
		pix.last  = last_s1;
	end

	assign pix_valid = valid_s1;

endmodule
`default_nettype wire

// File: rtl/lsbe_serial.sv
// Serializer: pattern bytes MSB first, then latch bytes, into the output register.
`timescale 1ns / 1ps
`default_nettype none
module lsbe_serial import lsbe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	input  wire pix_t             pix,
	output logic                  pix_take,
	input  wire logic [ChanW-1:0] zero_pat,
	input  wire logic [ChanW-1:0] one_pat,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [ChanW-1:0]      tx_byte,
	output logic                  run_last,
	output logic                  frame_done
);

	logic                busy_q;
	logic [PixBits-1:0]  shift_q;
	logic [BitCntW-1:0]  bits_left_q;
	logic [LatchW-1:0]   latch_left_q;
	logic                last_q;
	logic                out_valid_q;
	logic [ChanW-1:0]    tx_byte_q;
	logic                run_last_q;
	logic                frame_done_q;

	logic                emit;
	logic                fin;
	logic                in_pattern;
	logic [ChanW-1:0]    byte_nxt;

	assign in_pattern = (bits_left_q != '0);
	assign emit       = busy_q && (!out_valid_q || out_ready);
	assign fin        = in_pattern ? (bits_left_q == BitCntW'(1) && latch_left_q == '0)
	                               : (latch_left_q == LatchW'(1));
	assign byte_nxt   = in_pattern ? (shift_q[PixBits-1] ? one_pat : zero_pat) : '0;
	assign pix_take   = pix_valid && (!busy_q || (emit && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			bits_left_q  <= '0;
			latch_left_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pix_take) begin
				busy_q       <= 1'b1;
				bits_left_q  <= BitCntW'(PixBits);
				latch_left_q <= pix.latch;
			end else if (emit) begin
				if (fin) begin
					busy_q <= 1'b0;
				end
				if (in_pattern) begin
					bits_left_q <= bits_left_q - BitCntW'(1);
				end else begin
					latch_left_q <= latch_left_q - LatchW'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take) begin
			shift_q <= pix.bits;
			last_q  <= pix.last;
		end else if (emit && in_pattern) begin
			shift_q <= {shift_q[PixBits-2:0], 1'b0};
		end
		if (emit) begin
			tx_byte_q    <= byte_nxt;
			run_last_q   <= fin;
			frame_done_q <= fin && last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign tx_byte    = tx_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

endmodule
`default_nettype wire
